// ----- rtl/sfh_pkg.sv -----
// Shared types, register map and codes for the supervisory frame handshake core.
// No dependencies; every other file in rtl/ uses this package.
package sfh_pkg;

   localparam int BYTE_W   = 8;
   localparam int TICK_W   = 16;
   localparam int ATT_W    = 4;
   localparam int REQ_W    = 2;
   localparam int OUT_W    = 2;
   localparam int MATCH_W  = 3;
   localparam int BEAT_W   = 3;
   localparam int PADDR_W  = 5;
   localparam int PDATA_W  = 32;
   localparam int REG_IDX_W = 3;

   localparam logic [REQ_W-1:0] REQ_START = 2'd0;
   localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_FLAG    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ADDR    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CTRL    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MAX_ATT = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_BYTES   = 3'd5;

   localparam logic [BYTE_W-1:0] FLAG_RESET    = 8'h7E;
   localparam logic [BYTE_W-1:0] ADDR_RESET    = 8'h03;
   localparam logic [BYTE_W-1:0] CTRL_RESET    = 8'h03;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd3;
   localparam logic [ATT_W-1:0]  MAX_ATT_RESET = 4'd3;
   localparam logic [BYTE_W-1:0] BYTES_RESET   = 8'd5;

   localparam logic [BEAT_W-1:0] BEAT_FLAG0 = 3'd0;
   localparam logic [BEAT_W-1:0] BEAT_ADDR  = 3'd1;
   localparam logic [BEAT_W-1:0] BEAT_CTRL  = 3'd2;
   localparam logic [BEAT_W-1:0] BEAT_CHK   = 3'd3;
   localparam logic [BEAT_W-1:0] BEAT_FLAG1 = 3'd4;

   typedef enum logic [OUT_W-1:0] {
      HS_IDLE = 2'd0,
      HS_WAIT = 2'd1,
      HS_OK   = 2'd2,
      HS_FAIL = 2'd3
   } hs_phase_type;

   typedef enum logic [MATCH_W-1:0] {
      M_START = 3'd0,
      M_FLAG  = 3'd1,
      M_ADDR  = 3'd2,
      M_CTRL  = 3'd3,
      M_CHK   = 3'd4,
      M_DONE  = 3'd5
   } match_type;

   typedef struct packed {
      logic [BYTE_W-1:0] flag_byte;
      logic [BYTE_W-1:0] address_byte;
      logic [BYTE_W-1:0] control_byte;
      logic [TICK_W-1:0] timeout_ticks;
      logic [ATT_W-1:0]  max_attempts;
      logic [BYTE_W-1:0] bytes_per_attempt;
   } cfg_type;

   typedef struct packed {
      logic              frame;
      hs_phase_type      outcome;
      logic [ATT_W-1:0]  attempt_number;
      logic [MATCH_W-1:0] match_state;
   } rec_type;

endpackage

// ----- rtl/sfh_channel_if.sv -----
// Valid/ready channel interfaces for request and response transfers.
// Depends on sfh_pkg for field widths.
interface sfh_req_if;
   logic                         valid;
   logic                         ready;
   logic [sfh_pkg::REQ_W-1:0]    req_type;
   logic [sfh_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output req_type, output rx_byte, input ready);
   modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface sfh_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         tx_valid;
   logic [sfh_pkg::BYTE_W-1:0]   tx_byte;
   logic                         tx_last;
   logic [sfh_pkg::OUT_W-1:0]    outcome;
   logic [sfh_pkg::ATT_W-1:0]    attempt_number;
   logic [sfh_pkg::MATCH_W-1:0]  match_state;

   modport source (output valid, output tx_valid, output tx_byte, output tx_last,
                   output outcome, output attempt_number, output match_state,
                   input ready);
   modport sink   (input valid, input tx_valid, input tx_byte, input tx_last,
                   input outcome, input attempt_number, input match_state,
                   output ready);
endinterface

// ----- rtl/sfh_csr.sv -----
// APB-style configuration registers for the handshake core.
// Depends on sfh_pkg for the register map and cfg_type.
module sfh_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [sfh_pkg::PADDR_W-1:0]  paddr,
   input  logic [sfh_pkg::PDATA_W-1:0]  pwdata,
   output logic [sfh_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready,
   output sfh_pkg::cfg_type             cfg
);
   import sfh_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] idx;

   assign wr_en  = psel & penable & pwrite;
   assign idx    = paddr[PADDR_W-1:2];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_FLAG:    cfg_in.flag_byte         = pwdata[BYTE_W-1:0];
            REG_ADDR:    cfg_in.address_byte      = pwdata[BYTE_W-1:0];
            REG_CTRL:    cfg_in.control_byte      = pwdata[BYTE_W-1:0];
            REG_TIMEOUT: cfg_in.timeout_ticks     = pwdata[TICK_W-1:0];
            REG_MAX_ATT: cfg_in.max_attempts      = pwdata[ATT_W-1:0];
            REG_BYTES:   cfg_in.bytes_per_attempt = pwdata[BYTE_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_FLAG:    prdata = {{(PDATA_W-BYTE_W){1'b0}}, cfg_ff.flag_byte};
         REG_ADDR:    prdata = {{(PDATA_W-BYTE_W){1'b0}}, cfg_ff.address_byte};
         REG_CTRL:    prdata = {{(PDATA_W-BYTE_W){1'b0}}, cfg_ff.control_byte};
         REG_TIMEOUT: prdata = {{(PDATA_W-TICK_W){1'b0}}, cfg_ff.timeout_ticks};
         REG_MAX_ATT: prdata = {{(PDATA_W-ATT_W){1'b0}}, cfg_ff.max_attempts};
         REG_BYTES:   prdata = {{(PDATA_W-BYTE_W){1'b0}}, cfg_ff.bytes_per_attempt};
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_byte         <= FLAG_RESET;
         cfg_ff.address_byte      <= ADDR_RESET;
         cfg_ff.control_byte      <= CTRL_RESET;
         cfg_ff.timeout_ticks     <= TIMEOUT_RESET;
         cfg_ff.max_attempts      <= MAX_ATT_RESET;
         cfg_ff.bytes_per_attempt <= BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// ----- rtl/sfh_step.sv -----
// Handshake state registers and the single-pass update for one accepted transfer.
// Depends on sfh_pkg for codes, cfg_type and rec_type.
module sfh_step (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [sfh_pkg::REQ_W-1:0]   req_type,
   input  logic [sfh_pkg::BYTE_W-1:0]  rx_byte,
   input  sfh_pkg::cfg_type            cfg,
   output sfh_pkg::rec_type            rec
);
   import sfh_pkg::*;

   logic [MATCH_W-1:0] match_ff, match_in;
   hs_phase_type       phase_ff, phase_in;
   logic [ATT_W-1:0]   att_ff, att_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [BYTE_W-1:0]  bcnt_ff, bcnt_in;
   logic               frame;

   logic [BYTE_W-1:0]  chk;
   logic               is_flag;
   logic [MATCH_W-1:0] next_match;
   logic [BYTE_W-1:0]  lim_b;
   logic [TICK_W-1:0]  lim_t;
   logic [ATT_W-1:0]   lim_a;
   logic [BYTE_W-1:0]  bcnt_inc;
   logic [TICK_W-1:0]  tick_inc;
   logic               attempt_end;

   assign chk     = cfg.address_byte ^ cfg.control_byte;
   assign is_flag = (rx_byte == cfg.flag_byte);
   assign lim_b   = (cfg.bytes_per_attempt == '0) ? BYTE_W'(1) : cfg.bytes_per_attempt;
   assign lim_t   = (cfg.timeout_ticks == '0) ? TICK_W'(1) : cfg.timeout_ticks;
   assign lim_a   = (cfg.max_attempts == '0) ? ATT_W'(1) : cfg.max_attempts;
   assign bcnt_inc = (bcnt_ff == '1) ? bcnt_ff : bcnt_ff + BYTE_W'(1);
   assign tick_inc = (tick_ff == '1) ? tick_ff : tick_ff + TICK_W'(1);

   always_comb begin
      case (match_ff)
         M_FLAG:  next_match = is_flag ? M_FLAG :
                               (rx_byte == cfg.address_byte) ? M_ADDR : M_START;
         M_ADDR:  next_match = is_flag ? M_FLAG :
                               (rx_byte == cfg.control_byte) ? M_CTRL : M_START;
         M_CTRL:  next_match = is_flag ? M_FLAG :
                               (rx_byte == chk) ? M_CHK : M_START;
         M_CHK:   next_match = is_flag ? M_DONE : M_START;
         M_DONE:  next_match = M_DONE;
         default: next_match = is_flag ? M_FLAG : M_START;
      endcase
   end

   always_comb begin
      match_in    = match_ff;
      phase_in    = phase_ff;
      att_in      = att_ff;
      tick_in     = tick_ff;
      bcnt_in     = bcnt_ff;
      frame       = 1'b0;
      attempt_end = 1'b0;
      if (req_type == REQ_START) begin
         match_in = M_START;
         phase_in = HS_WAIT;
         att_in   = ATT_W'(1);
         tick_in  = '0;
         bcnt_in  = '0;
         frame    = 1'b1;
      end else if (phase_ff == HS_WAIT && req_type == REQ_BYTE) begin
         match_in = next_match;
         if (next_match == M_DONE) begin
            phase_in = HS_OK;
         end else begin
            bcnt_in     = bcnt_inc;
            attempt_end = (bcnt_inc >= lim_b);
         end
      end else if (phase_ff == HS_WAIT && req_type == REQ_TICK) begin
         tick_in     = tick_inc;
         attempt_end = (tick_inc >= lim_t);
      end
      if (attempt_end) begin
         if (att_ff < lim_a) begin
            att_in  = att_ff + ATT_W'(1);
            tick_in = '0;
            bcnt_in = '0;
            frame   = 1'b1;
         end else begin
            phase_in = HS_FAIL;
         end
      end
   end

   assign rec.frame          = frame;
   assign rec.outcome        = phase_in;
   assign rec.attempt_number = att_in;
   assign rec.match_state    = match_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= M_START;
         phase_ff <= HS_IDLE;
         att_ff   <= '0;
         tick_ff  <= '0;
         bcnt_ff  <= '0;
      end else if (accept) begin
         match_ff <= match_in;
         phase_ff <= phase_in;
         att_ff   <= att_in;
         tick_ff  <= tick_in;
         bcnt_ff  <= bcnt_in;
      end
   end
endmodule

// ----- rtl/sfh_tx_out.sv -----
// Result register and frame serializer: one status transfer or five frame transfers.
// Depends on sfh_pkg for rec_type, cfg_type and beat codes.
module sfh_tx_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  sfh_pkg::rec_type  rec,
   input  sfh_pkg::cfg_type  cfg,
   output logic              free,
   sfh_rsp_if.source         rsp_if
);
   import sfh_pkg::*;

   rec_type             rec_ff;
   logic                busy_ff;
   logic [BEAT_W-1:0]   beat_ff;
   logic                take;
   logic                last;
   logic [BYTE_W-1:0]   frame_byte;

   assign last = ~rec_ff.frame | (beat_ff == BEAT_FLAG1);
   assign take = busy_ff & rsp_if.ready;
   assign free = ~busy_ff | (take & last);

   always_comb begin
      unique case (beat_ff)
         BEAT_ADDR: frame_byte = cfg.address_byte;
         BEAT_CTRL: frame_byte = cfg.control_byte;
         BEAT_CHK:  frame_byte = cfg.address_byte ^ cfg.control_byte;
         default:   frame_byte = cfg.flag_byte;
      endcase
   end

   assign rsp_if.valid          = busy_ff;
   assign rsp_if.tx_valid       = rec_ff.frame;
   assign rsp_if.tx_byte        = rec_ff.frame ? frame_byte : '0;
   assign rsp_if.tx_last        = last;
   assign rsp_if.outcome        = rec_ff.outcome;
   assign rsp_if.attempt_number = rec_ff.attempt_number;
   assign rsp_if.match_state    = rec_ff.match_state;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= BEAT_FLAG0;
      end else if (load) begin
         busy_ff <= 1'b1;
         beat_ff <= BEAT_FLAG0;
      end else if (take & last) begin
         busy_ff <= 1'b0;
      end else if (take) begin
         beat_ff <= beat_ff + BEAT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff <= rec;
      end
   end
endmodule

// ----- rtl/supervisory_frame_handshake_core.sv -----
// Top level of the supervisory frame handshake core.
// Depends on sfh_pkg, sfh_channel_if, sfh_csr, sfh_step and sfh_tx_out.
//
// Usage:
//   req_if carries one request per transfer: start, a received byte, or a tick.
//   rsp_if returns the results: a start or retransmission yields five transfers
//   carrying the command frame (tx_valid high, tx_last on the closing flag);
//   every other request yields one status transfer with tx_valid low.
//   Status fields show the handshake state after the request.
//   The APB-style port holds six registers at byte addresses 0x00 to 0x14.
// Timing:
//   The request is absorbed at acceptance; its first result appears the next
//   cycle. Result transfers are paced by the single result register and its
//   beat counter and hold while rsp_if.ready is low; a new request is taken in
//   the cycle the previous last result transfer completes.
// Reset and stall:
//   Reset restores register defaults and returns the handshake to idle.
//   While rsp_if.ready is low the current result holds and req_if.ready
//   drops once the result register is occupied.
module supervisory_frame_handshake_core (
   input  logic                         clock,
   input  logic                         reset,
   sfh_req_if.sink                      req_if,
   sfh_rsp_if.source                    rsp_if,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [sfh_pkg::PADDR_W-1:0]  paddr,
   input  logic [sfh_pkg::PDATA_W-1:0]  pwdata,
   output logic [sfh_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready
);
   import sfh_pkg::*;

   cfg_type cfg;
   rec_type rec;
   logic    free;
   logic    accept;

   assign req_if.ready = free;
   assign accept       = req_if.valid & free;

   sfh_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sfh_step u_step (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_type (req_if.req_type),
      .rx_byte  (req_if.rx_byte),
      .cfg      (cfg),
      .rec      (rec)
   );

   sfh_tx_out u_tx_out (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .rec    (rec),
      .cfg    (cfg),
      .free   (free),
      .rsp_if (rsp_if)
   );
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for supervisory_frame_handshake_core: an in-bench predictor of the
// handshake checks every response transfer; requests and CSR writes are generated here.
// Depends on sfh_pkg, the sfh_req_if/sfh_rsp_if interfaces and the RTL under rtl/.
module testbench;
   import sfh_pkg::*;

   localparam int CLOCK_PERIOD   = 4;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int PHASE_ITEMS    = 28;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [REQ_W-1:0]  kind;
      logic [BYTE_W-1:0] data;
   } link_req_type;

   typedef struct packed {
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              tx_last;
      hs_phase_type      outcome;
      logic [ATT_W-1:0]  attempt;
      match_type         state;
   } tx_beat_type;

   typedef enum {FLOW_FREE, FLOW_COIN, FLOW_SPARSE, FLOW_ALTERNATE} flow_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   sfh_req_if req_ch ();
   sfh_rsp_if rsp_ch ();

   supervisory_frame_handshake_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_ch),
      .rsp_if  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // predictor state and register shadow
   cfg_type      shadow_cfg;
   hs_phase_type link_phase;
   match_type    echo_state;
   logic [ATT_W-1:0]  tries;
   logic [TICK_W-1:0] ticks_seen;
   logic [BYTE_W-1:0] bytes_seen;

   link_req_type pending_reqs[$];
   tx_beat_type  frame_expect[$];

   int   mismatches = 0;
   int   requests_seen = 0;
   int   transfers_seen = 0;
   int   handshakes_begun = 0;
   int   successes = 0;
   int   failures = 0;
   int   retransmits = 0;
   int   settings_applied = 0;
   int   cycle_count = 0;
   logic steady_send;
   int   hold_token;

   // ---------------- predictor ----------------
   function automatic match_type next_echo(match_type cur, logic [BYTE_W-1:0] b);
      logic is_flag;
      is_flag = (b == shadow_cfg.flag_byte);
      case (cur)
         M_FLAG: begin
            if (is_flag) return M_FLAG;
            return (b == shadow_cfg.address_byte) ? M_ADDR : M_START;
         end
         M_ADDR: begin
            if (is_flag) return M_FLAG;
            return (b == shadow_cfg.control_byte) ? M_CTRL : M_START;
         end
         M_CTRL: begin
            if (is_flag) return M_FLAG;
            return (b == (shadow_cfg.address_byte ^ shadow_cfg.control_byte))
                   ? M_CHK : M_START;
         end
         M_CHK:   return is_flag ? M_DONE : M_START;
         M_DONE:  return M_DONE;
         default: return is_flag ? M_FLAG : M_START;
      endcase
   endfunction

   task automatic push_beat(input logic v, input logic [BYTE_W-1:0] b, input logic last);
      tx_beat_type beat;
      beat.tx_valid = v;
      beat.tx_byte  = b;
      beat.tx_last  = last;
      beat.outcome  = link_phase;
      beat.attempt  = tries;
      beat.state    = echo_state;
      frame_expect.push_back(beat);
   endtask

   task automatic push_frame();
      push_beat(1'b1, shadow_cfg.flag_byte, 1'b0);
      push_beat(1'b1, shadow_cfg.address_byte, 1'b0);
      push_beat(1'b1, shadow_cfg.control_byte, 1'b0);
      push_beat(1'b1, shadow_cfg.address_byte ^ shadow_cfg.control_byte, 1'b0);
      push_beat(1'b1, shadow_cfg.flag_byte, 1'b1);
   endtask

   task automatic retry_or_give_up();
      logic [ATT_W-1:0] lim;
      lim = (shadow_cfg.max_attempts == '0) ? ATT_W'(1) : shadow_cfg.max_attempts;
      if (tries < lim) begin
         tries      = tries + 1'b1;
         ticks_seen = '0;
         bytes_seen = '0;
         retransmits++;
         push_frame();
      end else begin
         link_phase = HS_FAIL;
         failures++;
         push_beat(1'b0, '0, 1'b1);
      end
   endtask

   task automatic step_handshake(input logic [REQ_W-1:0] kind,
                                 input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] byte_lim;
      logic [TICK_W-1:0] tick_lim;
      byte_lim = (shadow_cfg.bytes_per_attempt == '0) ? BYTE_W'(1)
                                                     : shadow_cfg.bytes_per_attempt;
      tick_lim = (shadow_cfg.timeout_ticks == '0) ? TICK_W'(1) : shadow_cfg.timeout_ticks;
      if (kind == REQ_START) begin
         echo_state = M_START;
         link_phase = HS_WAIT;
         tries      = ATT_W'(1);
         ticks_seen = '0;
         bytes_seen = '0;
         handshakes_begun++;
         push_frame();
      end else if (link_phase != HS_WAIT || kind == REQ_UNUSED) begin
         push_beat(1'b0, '0, 1'b1);
      end else if (kind == REQ_BYTE) begin
         echo_state = next_echo(echo_state, data);
         if (echo_state == M_DONE) begin
            link_phase = HS_OK;
            successes++;
            push_beat(1'b0, '0, 1'b1);
         end else begin
            if (bytes_seen != '1) bytes_seen = bytes_seen + 1'b1;
            if (bytes_seen >= byte_lim) retry_or_give_up();
            else push_beat(1'b0, '0, 1'b1);
         end
      end else begin
         if (ticks_seen != '1) ticks_seen = ticks_seen + 1'b1;
         if (ticks_seen >= tick_lim) retry_or_give_up();
         else push_beat(1'b0, '0, 1'b1);
      end
   endtask

   // ---------------- request driver ----------------
   always @(posedge clock) begin
      logic offer;
      int   burst_left;
      int   gap_left;
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) void'(pending_reqs.pop_front());
         if (req_ch.valid && !req_ch.ready) begin
            offer = 1'b1;
         end else if (pending_reqs.size() == 0) begin
            offer = 1'b0;
         end else if (steady_send) begin
            offer = 1'b1;
         end else begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end
            if (gap_left > 0) begin
               gap_left--;
               offer = 1'b0;
            end else begin
               burst_left--;
               offer = 1'b1;
            end
         end
         req_ch.valid <= offer;
         if (offer) begin
            req_ch.req_type <= pending_reqs[0].kind;
            req_ch.rx_byte  <= pending_reqs[0].data;
         end
      end
   end

   // ---------------- response receiver ----------------
   always @(posedge clock) begin
      logic          take;
      flow_mode_type flow;
      int            mode_left;
      int            holdoff_left;
      int            hold_taken;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         flow         = FLOW_FREE;
         mode_left    = 0;
         holdoff_left = 0;
         hold_taken   = 0;
      end else begin
         if (hold_token != hold_taken) begin
            hold_taken   = hold_token;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (mode_left == 0) begin
            flow      = flow_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(8, 64);
         end
         mode_left--;
         case (flow)
            FLOW_FREE:   take = 1'b1;
            FLOW_COIN:   take = 1'($urandom_range(0, 1));
            FLOW_SPARSE: take = ($urandom_range(0, 4) == 0);
            default:     take = mode_left[0];
         endcase
         if (holdoff_left > 0) begin
            holdoff_left--;
            take = 1'b0;
         end
         rsp_ch.ready <= take;
      end
   end

   // ---------------- monitor and checker ----------------
   always @(posedge clock) begin
      tx_beat_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            requests_seen++;
            step_handshake(req_ch.req_type, req_ch.rx_byte);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            transfers_seen++;
            if (frame_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("transfer %0d arrived with nothing expected: valid=%0b byte=%02h",
                           transfers_seen, rsp_ch.tx_valid, rsp_ch.tx_byte);
            end else begin
               want = frame_expect.pop_front();
               if (rsp_ch.tx_valid !== want.tx_valid || rsp_ch.tx_byte !== want.tx_byte ||
                   rsp_ch.tx_last !== want.tx_last || rsp_ch.outcome !== want.outcome ||
                   rsp_ch.attempt_number !== want.attempt ||
                   rsp_ch.match_state !== want.state) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("mismatch on transfer %0d: expected valid=%0b byte=%02h %s",
                              transfers_seen, want.tx_valid, want.tx_byte,
                              $sformatf("last=%0b outcome=%0d attempt=%0d match=%0d",
                                        want.tx_last, want.outcome, want.attempt,
                                        want.state));
                     $display("   got valid=%0b byte=%02h %s",
                              rsp_ch.tx_valid, rsp_ch.tx_byte,
                              $sformatf("last=%0b outcome=%0d attempt=%0d match=%0d",
                                        rsp_ch.tx_last, rsp_ch.outcome,
                                        rsp_ch.attempt_number, rsp_ch.match_state));
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d transfers still expected",
                  cycle_count, frame_expect.size());
         $display("status: fail");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic write_csr(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_FLAG:    shadow_cfg.flag_byte         = value[BYTE_W-1:0];
         REG_ADDR:    shadow_cfg.address_byte      = value[BYTE_W-1:0];
         REG_CTRL:    shadow_cfg.control_byte      = value[BYTE_W-1:0];
         REG_TIMEOUT: shadow_cfg.timeout_ticks     = value[TICK_W-1:0];
         REG_MAX_ATT: shadow_cfg.max_attempts      = value[ATT_W-1:0];
         REG_BYTES:   shadow_cfg.bytes_per_attempt = value[BYTE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input cfg_type setting);
      write_csr(REG_FLAG, PDATA_W'(setting.flag_byte));
      write_csr(REG_ADDR, PDATA_W'(setting.address_byte));
      write_csr(REG_CTRL, PDATA_W'(setting.control_byte));
      write_csr(REG_TIMEOUT, PDATA_W'(setting.timeout_ticks));
      write_csr(REG_MAX_ATT, PDATA_W'(setting.max_attempts));
      write_csr(REG_BYTES, PDATA_W'(setting.bytes_per_attempt));
      settings_applied++;
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || frame_expect.size() != 0 || req_ch.valid)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [BYTE_W-1:0] data);
      link_req_type item;
      item.kind = kind;
      item.data = data;
      pending_reqs.push_back(item);
   endtask

   function automatic logic [BYTE_W-1:0] echo_field(int pos);
      case (pos)
         1:       return shadow_cfg.address_byte;
         2:       return shadow_cfg.control_byte;
         3:       return shadow_cfg.address_byte ^ shadow_cfg.control_byte;
         default: return shadow_cfg.flag_byte;
      endcase
   endfunction

   // push an echo frame; flip one bit of the byte at bad_pos, none if out of range
   task automatic queue_echo(input int bad_pos);
      logic [BYTE_W-1:0] b;
      for (int k = 0; k < 5; k++) begin
         b = echo_field(k);
         if (k == bad_pos) b = b ^ (8'h01 << $urandom_range(0, 7));
         queue_req(REQ_BYTE, b);
      end
   endtask

   task automatic queue_noise();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 9)
         queue_req(REQ_TICK, 8'($urandom_range(0, 255)));
      else if (pick < 13)
         queue_req(REQ_BYTE, 8'($urandom_range(0, 255)));
      else if (pick < 17)
         queue_req(REQ_BYTE, echo_field($urandom_range(0, 4)));
      else if (pick < 18)
         queue_req(REQ_UNUSED, 8'($urandom_range(0, 255)));
      else
         queue_req(REQ_START, 8'($urandom_range(0, 255)));
   endtask

   task automatic queue_random_phase(input int budget);
      int left;
      int n;
      left = budget;
      while (left > 0) begin
         queue_req(REQ_START, 8'($urandom_range(0, 255)));
         left--;
         n = $urandom_range(0, 4);
         repeat (n) queue_noise();
         left -= n;
         if ($urandom_range(0, 9) < 7) begin
            queue_echo(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : -1);
            left -= 5;
         end
         n = $urandom_range(0, 3);
         repeat (n) queue_noise();
         left -= n;
      end
   endtask

   initial begin
      cfg_type setting;
      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_START;
      req_ch.rx_byte  = '0;
      rsp_ch.ready    = 1'b0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      steady_send     = 1'b0;
      hold_token      = 0;
      shadow_cfg.flag_byte         = FLAG_RESET;
      shadow_cfg.address_byte      = ADDR_RESET;
      shadow_cfg.control_byte      = CTRL_RESET;
      shadow_cfg.timeout_ticks     = TIMEOUT_RESET;
      shadow_cfg.max_attempts      = MAX_ATT_RESET;
      shadow_cfg.bytes_per_attempt = BYTES_RESET;
      link_phase = HS_IDLE;
      echo_state = M_START;
      tries      = '0;
      ticks_seen = '0;
      bytes_seen = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed pass on reset register values
      queue_req(REQ_BYTE, 8'hFF);
      queue_req(REQ_TICK, 8'h00);
      queue_req(REQ_UNUSED, 8'hFF);
      queue_req(REQ_START, 8'h00);
      queue_echo(-1);
      queue_req(REQ_BYTE, FLAG_RESET);
      queue_req(REQ_START, 8'h00);
      queue_req(REQ_BYTE, FLAG_RESET);
      queue_req(REQ_START, 8'hFF);
      repeat (3) queue_req(REQ_TICK, 8'h00);
      queue_req(REQ_BYTE, FLAG_RESET);
      queue_req(REQ_BYTE, ADDR_RESET);
      queue_req(REQ_BYTE, CTRL_RESET);
      queue_req(REQ_BYTE, 8'h55);
      queue_req(REQ_BYTE, 8'h00);
      repeat (3) queue_req(REQ_TICK, 8'h00);
      queue_req(REQ_TICK, 8'hFF);
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         setting.flag_byte         = 8'($urandom_range(0, 255));
         setting.address_byte      = ($urandom_range(0, 7) == 0) ? setting.flag_byte
                                                                 : 8'($urandom_range(0, 255));
         setting.control_byte      = 8'($urandom_range(0, 255));
         setting.timeout_ticks     = 16'($urandom_range(1, 10));
         setting.max_attempts      = 4'($urandom_range(1, 15));
         setting.bytes_per_attempt = 8'($urandom_range(1, 12));
         if (phase == 0) begin
            // zero limits act as one
            setting = '{flag_byte: 8'h00, address_byte: 8'hFF, control_byte: 8'h00,
                        timeout_ticks: 16'd0, max_attempts: 4'd0, bytes_per_attempt: 8'd0};
         end else if (phase == 1) begin
            setting = '{flag_byte: 8'hFF, address_byte: 8'h00, control_byte: 8'hFF,
                        timeout_ticks: 16'hFFFF, max_attempts: 4'd15,
                        bytes_per_attempt: 8'hFF};
         end else if (phase == 5) begin
            setting.timeout_ticks = 16'd1;
            setting.max_attempts  = 4'd15;
         end
         apply_settings(setting);
         queue_random_phase(PHASE_ITEMS);
         if (phase == 2) begin
            // keep offering while the receiver holds off
            steady_send <= 1'b1;
            hold_token  <= hold_token + 1;
         end
         wait_idle();
         steady_send <= 1'b0;
      end

      repeat (16) @(posedge clock);
      $display("covered %0d requests and %0d response transfers under %0d register settings",
               requests_seen, transfers_seen, settings_applied + 1);
      $display("handshakes: %0d started, %0d succeeded, %0d failed, %0d retransmissions",
               handshakes_begun, successes, failures, retransmits);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0 && frame_expect.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
